/* design/b32ae_pkg.sv */
// Shared types, constants and helper functions for the base32 address encoder.
package b32ae_pkg;

    localparam int HASH_BYTES = 32;
    localparam int CNT_W      = $clog2(HASH_BYTES + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int SUFFIX_LEN = 8;
    localparam int GROUP_BITS = 5;

    // Result of folding one byte into the bit accumulator.
    typedef struct packed {
        logic [4:0] code0;
        logic [4:0] code1;
        logic       two;     // code1 is valid
        logic [3:0] acc;     // leftover bits, right-aligned
        logic [2:0] pend;    // number of leftover bits
    } enc_t;

    // One classified input beat: up to four characters, optional suffix.
    typedef struct packed {
        logic [3:0][4:0] codes;  // codes[0] goes out first
        logic [2:0]      count;  // 1..4
        logic            is_end; // append the suffix after the codes
    } job_t;

    function automatic enc_t enc_byte(logic [3:0] acc, logic [2:0] pend, logic [7:0] b);
        logic [11:0] a;
        logic [3:0]  p1;
        logic [3:0]  p2;
        logic [3:0]  p3;
        enc_t        r;
        a       = {acc, b};
        p1      = {1'b0, pend} + 4'd8;
        p2      = p1 - 4'(GROUP_BITS);
        p3      = p2 - 4'(GROUP_BITS);
        r.code0 = 5'(a >> p2);
        r.acc   = a[3:0];
        if (p2 >= 4'(GROUP_BITS)) begin
            r.code1 = 5'(a >> p3);
            r.two   = 1'b1;
            r.pend  = p3[2:0];
        end else begin
            r.code1 = '0;
            r.two   = 1'b0;
            r.pend  = p2[2:0];
        end
        return r;
    endfunction

    // a-z then 2-7
    function automatic logic [6:0] b32_char(logic [4:0] code);
        if (code < 5'd26) begin
            return 7'(8'h61 + {3'b0, code});
        end else begin
            return 7'(8'h32 + {3'b0, code} - 8'd26);
        end
    endfunction

    // ".b32.i2p"
    function automatic logic [6:0] suffix_char(logic [2:0] idx);
        logic [6:0] c;
        case (idx)
            3'd0:    c = 7'h2E;
            3'd1:    c = 7'h62;
            3'd2:    c = 7'h33;
            3'd3:    c = 7'h32;
            3'd4:    c = 7'h2E;
            3'd5:    c = 7'h69;
            3'd6:    c = 7'h32;
            3'd7:    c = 7'h70;
            default: c = 7'h2E;
        endcase
        return c;
    endfunction

endpackage

/* design/base32_address_encoder.sv */
// Top level of the lowercase base32 address encoder.
//
// Input channel (s_*): one hash byte per beat, most significant bit encoded
// first. Every HASH_BYTES bytes form one address.
// Output channel (m_*): one ASCII character per beat. Each complete 5-bit
// group becomes a character from a-z, 2-7. After the last hash byte a zero
// pad byte is folded in, leftover bits under five are dropped, and the
// suffix ".b32.i2p" follows; m_tlast marks its final character.
// The first character of a byte leaves the job queue through the output
// register. The emitter sends one character per cycle while m_tready is high
// and a job is queued; a byte yields one or two characters (1.6 on average),
// the end of an address adds up to ten, and the output port sets the rate.
// A four-entry job queue sits between the bit accumulator and the emitter,
// so input beats keep flowing while m_tready is low until the queue fills;
// s_tready then drops. A stalled output beat holds its data.
// Reset (aresetn low, synchronous) clears the accumulator, byte count,
// queue and output valid flag; the next byte starts a new address.
module base32_address_encoder
    import b32ae_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] hash_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic       m_tlast    // last_char
);

    job_t       push_job;
    job_t       head_job;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic [6:0] out_char;

    // Accumulate bits and classify each beat into a job.
    b32ae_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .fifo_full (full),
        .in_ready  (s_tready),
        .job_push  (push),
        .job       (push_job)
    );

    // Decouple the two sides.
    b32ae_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (push_job),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .rd_job  (head_job)
    );

    // Emit characters through a registered output stage.
    b32ae_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (empty),
        .head       (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_char   (out_char),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

/* design/b32ae_front.sv */
// Front end: accumulate hash bits, cut 5-bit groups, mark the end of an address.
module b32ae_front
    import b32ae_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       fifo_full,
    output logic       in_ready,
    output logic       job_push,
    output job_t       job
);

    logic [3:0]       acc_reg,  acc_next;
    logic [2:0]       pend_reg, pend_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    enc_t             e1, e2;
    logic             at_end;

    assign in_ready = !fifo_full;
    assign job_push = in_valid && in_ready;
    assign at_end   = (cnt_reg == CNT_W'(HASH_BYTES - 1));

    always_comb begin
        e1 = enc_byte(acc_reg, pend_reg, in_byte);
        e2 = enc_byte(e1.acc, e1.pend, 8'h00);
        job.is_end = at_end;
        if (e1.two) begin
            job.codes = {e2.code1, e2.code0, e1.code1, e1.code0};
        end else begin
            job.codes = {5'd0, e2.code1, e2.code0, e1.code0};
        end
        job.count = (e1.two ? 3'd2 : 3'd1)
                  + (at_end ? (e2.two ? 3'd2 : 3'd1) : 3'd0);
        if (at_end) begin
            acc_next  = '0;
            pend_next = '0;
            cnt_next  = '0;
        end else begin
            acc_next  = e1.acc;
            pend_next = e1.pend;
            cnt_next  = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            pend_reg <= '0;
            cnt_reg  <= '0;
        end else if (job_push) begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* design/b32ae_fifo.sv */
// Short job queue between the front end and the character emitter.
module b32ae_fifo
    import b32ae_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t wr_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t rd_job
);

    job_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full   = (cnt_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + PTR_W'(1);
            end
            if (pop) begin
                rp_reg <= rp_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

/* design/b32ae_back.sv */
// Back end: walk queued jobs, emit one character beat per cycle unless stalled.
module b32ae_back
    import b32ae_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fifo_empty,
    input  job_t       head,
    output logic       pop,
    output logic       out_valid,
    output logic [6:0] out_char,
    output logic       out_last,
    input  logic       out_ready
);

    typedef enum logic {ST_CODES, ST_SUFFIX} state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg,   idx_next;
    logic [2:0] sidx_reg,  sidx_next;
    logic       vld_reg,   vld_next;
    logic [6:0] chr_reg,   chr_next;
    logic       lst_reg,   lst_next;
    logic       advance;

    assign advance = !fifo_empty && (!vld_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sidx_next  = sidx_reg;
        vld_next   = vld_reg && !out_ready;
        chr_next   = chr_reg;
        lst_next   = lst_reg;
        pop        = 1'b0;
        if (advance) begin
            vld_next = 1'b1;
            case (state_reg)
                ST_CODES: begin
                    chr_next = b32_char(head.codes[idx_reg]);
                    lst_next = 1'b0;
                    if (idx_reg == 2'(head.count - 3'd1)) begin
                        idx_next = '0;
                        if (head.is_end) begin
                            state_next = ST_SUFFIX;
                            sidx_next  = '0;
                        end else begin
                            pop = 1'b1;
                        end
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                ST_SUFFIX: begin
                    chr_next = suffix_char(sidx_reg);
                    lst_next = (sidx_reg == 3'(SUFFIX_LEN - 1));
                    sidx_next = sidx_reg + 3'd1;
                    if (sidx_reg == 3'(SUFFIX_LEN - 1)) begin
                        pop        = 1'b1;
                        state_next = ST_CODES;
                    end
                end
                default: begin
                    state_next = ST_CODES;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CODES;
            idx_reg   <= '0;
            sidx_reg  <= '0;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sidx_reg  <= sidx_next;
            vld_reg   <= vld_next;
        end
        chr_reg <= chr_next;
        lst_reg <= lst_next;
    end

    assign out_valid = vld_reg;
    assign out_char  = chr_reg;
    assign out_last  = lst_reg;

endmodule

/* test/base32_address_encoder_checker.sv */
// Channel monitor, character predictor and comparator for the base32 address encoder.
module base32_address_encoder_checker
    import b32ae_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    output int         errors,
    output int         outstanding
);

    localparam logic [8*32-1:0] B32_ALPHABET = "abcdefghijklmnopqrstuvwxyz234567";
    localparam logic [8*8-1:0]  ADDR_SUFFIX  = ".b32.i2p";

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } addr_char_t;

    addr_char_t  char_q[$];
    logic [11:0] acc_bits  = '0;
    int          acc_count = 0;
    int          hash_pos  = 0;
    int          err_total = 0;

    function automatic logic [6:0] alphabet_at(int idx);
        return B32_ALPHABET[8*(31-idx) +: 7];
    endfunction

    function automatic logic [6:0] suffix_at(int idx);
        return ADDR_SUFFIX[8*(7-idx) +: 7];
    endfunction

    // Shift a byte in and queue a character for every full 5-bit group.
    task automatic fold_byte(input logic [7:0] b);
        logic [11:0] shifted;
        addr_char_t  c;
        acc_bits  = {acc_bits[3:0], b};
        acc_count = acc_count + 8;
        while (acc_count >= GROUP_BITS) begin
            acc_count = acc_count - GROUP_BITS;
            shifted   = acc_bits >> acc_count;
            c.code    = alphabet_at(int'(shifted[4:0]));
            c.last    = 1'b0;
            char_q.push_back(c);
        end
    endtask

    task automatic predict_address_chars(input logic [7:0] b);
        addr_char_t c;
        fold_byte(b);
        if (hash_pos >= HASH_BYTES - 1) begin
            // pad byte, then the suffix; leftover bits are dropped
            fold_byte(8'h00);
            for (int k = 0; k < SUFFIX_LEN; k++) begin
                c.code = suffix_at(k);
                c.last = (k == SUFFIX_LEN - 1);
                char_q.push_back(c);
            end
            acc_bits  = '0;
            acc_count = 0;
            hash_pos  = 0;
        end else begin
            hash_pos = hash_pos + 1;
        end
    endtask

    always @(posedge aclk) begin
        addr_char_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (char_q.size() == 0) begin
                    if (err_total < 10)
                        $display("unexpected char beat: tdata=%h tlast=%b", m_tdata, m_tlast);
                    err_total = err_total + 1;
                end else begin
                    want = char_q.pop_front();
                    if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last) begin
                        if (err_total < 10)
                            $display({"char mismatch: expected tdata=%h tlast=%b, ",
                                      "got tdata=%h tlast=%b"},
                                     {1'b0, want.code}, want.last, m_tdata, m_tlast);
                        err_total = err_total + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_address_chars(s_tdata);
        end
        errors      <= err_total;
        outstanding <= char_q.size();
    end

endmodule

/* test/base32_address_encoder_tb.sv */
// Stimulus, clock, reset and verdict for the base32 address encoder testbench.
module base32_address_encoder_tb
    import b32ae_pkg::*;
;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] hash_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [6:0] char_code, [7] zero
    logic       m_tlast;            // last_char

    int errors;
    int outstanding;

    // Handshake flags, registered at the rising edge so the falling-edge
    // drivers see settled values.
    logic s_took  = 1'b0;
    logic rx_took = 1'b0;

    // Idle modes, changed per phase: when set, that side never idles.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_wait   = 0;

    base32_address_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    base32_address_encoder_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        s_took  <= aresetn && s_tvalid && s_tready;
        rx_took <= aresetn && m_tvalid && m_tready;
    end

    // Character sink: after every accepted beat draw a random stall length (zero
    // when rx_steady is set), hold tready low for that long, then raise it again.
    always @(negedge aclk) begin
        if (rx_took)
            rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait = rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one hash byte after a possibly empty idle gap; hold it until accepted.
    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_hash_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(negedge aclk); while (!s_took);
    endtask

    // Extremes, alternating bits and patterns that land single set or clear
    // bits in every 5-bit group position.
    logic [7:0] directed_bytes [24] = '{
        8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hAA, 8'h55,
        8'hF8, 8'h07, 8'hC1, 8'h3E, 8'h00, 8'h00, 8'hFF, 8'hFF,
        8'h84, 8'h21, 8'h10, 8'h42, 8'h08, 8'h7B, 8'hDE, 8'hF7
    };

    initial begin
        int         sent;
        int         mode;
        logic [7:0] b;
        sent = 0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed bytes, with both sides idling at random.
        foreach (directed_bytes[i]) begin
            send_hash_byte(directed_bytes[i]);
            sent++;
        end

        // Random bytes up to an address boundary, 192 bytes in all; the
        // idle mode changes every 16 bytes so steady and stalled stretches mix.
        while (sent < 6 * HASH_BYTES) begin
            if (sent % 16 == 0) begin
                mode      = $urandom_range(0, 3);
                tx_steady = (mode == 0) || (mode == 2);
                rx_steady = (mode == 0) || (mode == 1);
            end
            case ($urandom_range(0, 7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_hash_byte(b);
            sent++;
        end
        s_tvalid  <= 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Drain the expected characters, then watch a little longer for strays.
        wait (outstanding == 0);
        repeat (20) @(negedge aclk);

        if (errors == 0) begin
            $display("[base32_address_encoder] OK");
        end else begin
            $display("[base32_address_encoder] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("[base32_address_encoder] ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/b32ae_pkg.sv
design/b32ae_front.sv
design/b32ae_fifo.sv
design/b32ae_back.sv
design/base32_address_encoder.sv
test/base32_address_encoder_checker.sv
test/base32_address_encoder_tb.sv
